>>> src/periodic_task_timer_slots_core_defines.svh
`ifndef PERIODIC_TASK_TIMER_SLOTS_CORE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_SLOTS_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define PTTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ptts check failed");

// next-cycle implication, reset masked
`define PTTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ptts check failed");

`endif

>>> src/ptts_pkg.sv
`default_nettype none
package ptts_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int NUM_SLOTS_DEF = 16;
    localparam int SLOT_FIELD_W  = 4;
    localparam int PERIOD_W      = 32;
    localparam int ELAPSED_W     = 33;
    localparam int STEP_W        = 16;
    localparam int CMD_W         = 2;
    localparam int KIND_W        = 3;
    localparam int SDATA_W       = 40;
    localparam int MDATA_W       = 8;
    localparam int CFG_IDX_W     = 1;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_EN = 1'b0,
        CFG_STEP   = 1'b1
    } cfg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_REGISTER = 2'd1,
        CMD_CANCEL   = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 3'd0,
        KIND_CANCELLED  = 3'd1,
        KIND_FIRED      = 3'd2,
        KIND_DONE       = 3'd3,
        KIND_FULL       = 3'd4,
        KIND_UNKNOWN    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONE,
        ST_READ,
        ST_CALC,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> src/ptts_slot_ram.sv
`default_nettype none
module ptts_slot_ram #(
    parameter int DEPTH = ptts_pkg::TABLE_DEPTH,
    parameter int IDX_W = ptts_pkg::SLOT_FIELD_W
) (
    input  wire logic                           aclk,
    input  wire logic                           we_period,
    input  wire logic                           we_elapsed,
    input  wire logic [IDX_W-1:0]               addr,
    input  wire logic [ptts_pkg::PERIOD_W-1:0]  wr_period,
    input  wire logic [ptts_pkg::ELAPSED_W-1:0] wr_elapsed,
    output logic      [ptts_pkg::PERIOD_W-1:0]  rd_period,
    output logic      [ptts_pkg::ELAPSED_W-1:0] rd_elapsed
);
    import ptts_pkg::*;

    logic [PERIOD_W-1:0]  period_mem  [DEPTH];
    logic [ELAPSED_W-1:0] elapsed_mem [DEPTH];
    logic [PERIOD_W-1:0]  rd_period_reg;
    logic [ELAPSED_W-1:0] rd_elapsed_reg;

    always_ff @(posedge aclk) begin
        if (we_period) begin
            period_mem[addr] <= wr_period;
        end
        if (we_elapsed) begin
            elapsed_mem[addr] <= wr_elapsed;
        end
        rd_period_reg  <= period_mem[addr];
        rd_elapsed_reg <= elapsed_mem[addr];
    end

    assign rd_period  = rd_period_reg;
    assign rd_elapsed = rd_elapsed_reg;

endmodule
`default_nettype wire

>>> src/periodic_task_timer_slots_core.sv
`default_nettype none
// channel  | ports        | tdata (lsb up)             | tuser (lsb up)   | tlast
// ---------+--------------+----------------------------+------------------+------
// input    | s_t*         | period[31:0], slot[35:32]  | command[1:0]     | -
// result   | m_t*         | slot_number[3:0]           | result_kind[2:0] | last
// config   | cfg_*        | index 0 running_enable, index 1 step_size
//
// Register and cancel go through ST_ONE to the result. An accepted tick walks the slot
// table with one 33-bit adder/comparator: ST_READ does the registered table read, skipping
// inactive slots; ST_CALC does add/compare/write; ST_DONE ends (no walk if run is off).
// Reset clears active bits and run enable, sets step to 100; no table clearing pass.
// A result that cannot be handed off stalls the walk; input ready only when idle.
module periodic_task_timer_slots_core #(
    parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ptts_pkg::SDATA_W-1:0]   s_tdata,   // period, slot
    input  wire logic [ptts_pkg::CMD_W-1:0]     s_tuser,   // command
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ptts_pkg::MDATA_W-1:0]   m_tdata,   // slot_number
    output logic      [ptts_pkg::KIND_W-1:0]    m_tuser,   // result_kind
    output logic                                m_tlast,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ptts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ptts_pkg::STEP_W-1:0]    cfg_wdata
);
    import ptts_pkg::*;

    `include "periodic_task_timer_slots_core_defines.svh"

    localparam int SLOT_COUNT = (NUM_SLOTS < TABLE_DEPTH) ? NUM_SLOTS : TABLE_DEPTH;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_FIELD_W:0] SLOT_LIMIT = (SLOT_FIELD_W + 1)'(SLOT_COUNT);
    localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(SLOT_COUNT - 1);

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [PERIOD_W-1:0]     period_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SLOT_COUNT-1:0]   active_reg, active_next;
    logic                    run_en_reg;
    logic [STEP_W-1:0]       step_reg;

    logic                    m_valid_reg;
    kind_t                   m_kind_reg;
    logic [SLOT_FIELD_W-1:0] m_slot_reg;
    logic                    m_last_reg;

    logic                    s_xfer;
    cmd_t                    s_cmd;
    logic                    out_free;
    logic                    any_free;
    logic [IDX_W-1:0]        free_idx;
    logic                    cancel_ok;
    logic                    last_idx;
    logic [ELAPSED_W-1:0]    sum;
    logic                    fire;

    logic                    emit;
    kind_t                   o_kind;
    logic [SLOT_FIELD_W-1:0] o_slot;
    logic                    o_last;
    logic                    we_period;
    logic                    we_elapsed;
    logic [IDX_W-1:0]        mem_addr;
    logic [ELAPSED_W-1:0]    wr_elapsed;
    logic [PERIOD_W-1:0]     rd_period;
    logic [ELAPSED_W-1:0]    rd_elapsed;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign s_cmd    = cmd_t'(s_tuser);
    assign out_free = !m_valid_reg || m_tready;
    assign last_idx = (idx_reg == LAST_IDX);
    assign cancel_ok = ({1'b0, slot_reg} < SLOT_LIMIT) && active_reg[slot_reg[IDX_W-1:0]];
    assign sum      = rd_elapsed + ELAPSED_W'(step_reg);
    assign fire     = (sum >= ELAPSED_W'(rd_period));

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    ptts_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk       (aclk),
        .we_period  (we_period),
        .we_elapsed (we_elapsed),
        .addr       (mem_addr),
        .wr_period  (period_reg),
        .wr_elapsed (wr_elapsed),
        .rd_period  (rd_period),
        .rd_elapsed (rd_elapsed)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_cmd)
                        CMD_TICK:     state_next = run_en_reg ? ST_READ : ST_DONE;
                        CMD_REGISTER: state_next = ST_ONE;
                        CMD_CANCEL:   state_next = ST_ONE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (active_reg[idx_reg]) begin
                    state_next = ST_CALC;
                end else if (last_idx) begin
                    state_next = ST_DONE;
                end
            end
            ST_CALC: begin
                if (!fire || out_free) begin
                    state_next = last_idx ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        emit        = 1'b0;
        o_kind      = KIND_DONE;
        o_slot      = '0;
        o_last      = 1'b0;
        we_period   = 1'b0;
        we_elapsed  = 1'b0;
        wr_elapsed  = '0;
        mem_addr    = idx_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    idx_next = '0;
                end
            end
            ST_ONE: begin
                if (cmd_reg == CMD_REGISTER) begin
                    mem_addr = free_idx;
                end
                if (out_free) begin
                    emit   = 1'b1;
                    o_last = 1'b1;
                    if (cmd_reg == CMD_REGISTER) begin
                        if (any_free) begin
                            we_period             = 1'b1;
                            we_elapsed            = 1'b1;
                            active_next[free_idx] = 1'b1;
                            o_kind                = KIND_REGISTERED;
                            o_slot                = SLOT_FIELD_W'(free_idx);
                        end else begin
                            o_kind = KIND_FULL;
                        end
                    end else if (cancel_ok) begin
                        active_next[slot_reg[IDX_W-1:0]] = 1'b0;
                        o_kind                           = KIND_CANCELLED;
                        o_slot                           = slot_reg;
                    end else begin
                        o_kind = KIND_UNKNOWN;
                    end
                end
            end
            ST_READ: begin
                if (!active_reg[idx_reg] && !last_idx) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CALC: begin
                if (!fire) begin
                    we_elapsed = 1'b1;
                    wr_elapsed = sum;
                    if (!last_idx) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else if (out_free) begin
                    emit       = 1'b1;
                    o_kind     = KIND_FIRED;
                    o_slot     = SLOT_FIELD_W'(idx_reg);
                    we_elapsed = 1'b1;
                    if (!last_idx) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit   = 1'b1;
                    o_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            run_en_reg  <= 1'b0;
            step_reg    <= STEP_RESET;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            idx_reg    <= idx_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RUN_EN: run_en_reg <= cfg_wdata[0];
                    CFG_STEP:   step_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg    <= s_cmd;
            period_reg <= s_tdata[PERIOD_W-1:0];
            slot_reg   <= s_tdata[PERIOD_W +: SLOT_FIELD_W];
        end
        if (emit) begin
            m_kind_reg <= o_kind;
            m_slot_reg <= o_slot;
            m_last_reg <= o_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(MDATA_W - SLOT_FIELD_W){1'b0}}, m_slot_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `PTTS_ASSERT_NOW(a_no_overwrite, aclk, aresetn, emit, (!m_valid_reg || m_tready))
    `PTTS_ASSERT_NEXT(a_active_to_calc, aclk, aresetn,
        (state_reg == ST_READ) && active_reg[idx_reg], (state_reg == ST_CALC))
    `PTTS_ASSERT_NEXT(a_register_grows, aclk, aresetn, emit && (o_kind == KIND_REGISTERED),
        ($countones(active_reg) == $countones($past(active_reg)) + 1))

endmodule
`default_nettype wire
